### src/q64_pkg.sv
// Package for the Q64.64 arithmetic unit: payload structs, codes, controller/datapath links.
// No dependencies.
package q64_pkg;

  localparam int FRACTION_BITS = 64;

  typedef enum logic [1:0] {
    CMD_MUL = 2'd0,
    CMD_DIV = 2'd1,
    CMD_MINV = 2'd2,
    CMD_INV = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_MUL_OVF = 2'd1,
    ST_DIV_ZERO = 2'd2,
    ST_INV_SMALL = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic signed [63:0] a_high;
    logic [63:0] a_low;
    logic signed [63:0] b_high;
    logic [63:0] b_low;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] result_high;
    logic [63:0] result_low;
    logic [1:0] status;
  } out_item_t;

  // Datapath operations issued by the controller.
  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_LOAD = 3'd1,  // capture operands, form magnitudes
    OP_MAC = 3'd2,   // one 32x32 partial product into the accumulator
    OP_DSTEP = 3'd3, // one restoring division step
    OP_CHK = 3'd4,   // set up invert check multiply
    OP_FIN = 3'd5    // finish: sign, correction, result register
  } op_t;

  typedef struct packed {
    op_t op;
    logic [4:0] idx;    // partial product index
    logic [7:0] shift;  // accumulator word offset in 32-bit units (<<5)
  } dp_cmd_t;

  typedef struct packed {
    logic b_zero;
    logic v_small;
  } dp_status_t;

endpackage

### src/q64_datapath.sv
// Datapath of the Q64.64 unit: operand registers, one 32x32 multiplier with
// a 256-bit accumulator, a one-bit-per-cycle restoring divider. Uses q64_pkg.
module q64_datapath #(
  parameter int FRAC = q64_pkg::FRACTION_BITS
) (
  input  logic clk,
  input  q64_pkg::in_item_t in_item,
  input  q64_pkg::dp_cmd_t dcmd,
  output q64_pkg::dp_status_t dstat,
  output q64_pkg::out_item_t res
);

  logic [1:0] cmd;
  logic [127:0] mb;
  logic neg, nega;
  logic [255:0] acc;
  logic [127:0] rem, quo, dsr;
  logic [127+FRAC:0] dvd;
  logic [127:0] x_op, y_op;
  logic [31:0] pa, pb;
  logic [63:0] prod;
  logic [255:0] prod_sh;
  logic [128:0] rem_sh, rem_sub;
  logic [127:0] fin;
  q64_pkg::status_t fin_st;
  logic [1:0] xi, yi;

  assign dstat.b_zero = (mb == '0);
  assign dstat.v_small = (mb[63:1] == '0);

  // idx picks x limb (bits 3:2) and y limb (bits 1:0)
  assign xi = dcmd.idx[3:2];
  assign yi = dcmd.idx[1:0];
  assign pa = x_op[xi*32 +: 32];
  assign pb = y_op[yi*32 +: 32];
  assign prod = pa * pb;
  assign prod_sh = {192'd0, prod} << dcmd.shift;

  assign rem_sh = {rem, dvd[127+FRAC]};
  assign rem_sub = rem_sh - {1'b0, dsr};

  // inverse multiply leaves out low x low, and its result is taken 64 bits higher in acc
  always_comb begin
    fin = '0;
    fin_st = q64_pkg::ST_OK;
    unique case (cmd)
      q64_pkg::CMD_MUL: begin
        fin = neg ? -acc[127+FRAC:FRAC] : acc[127+FRAC:FRAC];
        if (acc[255:128+FRAC] != '0) fin_st = q64_pkg::ST_MUL_OVF;
      end
      q64_pkg::CMD_DIV: begin
        if (mb == '0) fin_st = q64_pkg::ST_DIV_ZERO;
        else fin = neg ? -quo : quo;
      end
      q64_pkg::CMD_MINV: fin = nega ? -acc[255:128] : acc[255:128];
      default: begin
        if (mb[63:1] == '0) fin_st = q64_pkg::ST_INV_SMALL;
        else fin = (acc[255:192] != 64'd1) ? quo + 128'd1 : quo;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (dcmd.op)
      q64_pkg::OP_LOAD: begin
        cmd <= in_item.cmd;
        neg <= in_item.a_high[63] ^ in_item.b_high[63];
        nega <= in_item.a_high[63];
        if (in_item.cmd == q64_pkg::CMD_MUL || in_item.cmd == q64_pkg::CMD_DIV)
          mb <= in_item.b_high[63] ? -{in_item.b_high, in_item.b_low}
                                   : {in_item.b_high, in_item.b_low};
        else
          mb <= {in_item.b_high, in_item.b_low};
        acc <= '0;
        rem <= '0;
        quo <= '0;
        if (in_item.cmd == q64_pkg::CMD_INV) begin
          dvd <= {64'd1, 64'd0, {FRAC{1'b0}}};
          dsr <= {64'd0, in_item.b_low};
        end else begin
          dvd <= {(in_item.a_high[63] ? -{in_item.a_high, in_item.a_low}
                                      : {in_item.a_high, in_item.a_low}), {FRAC{1'b0}}};
          dsr <= in_item.b_high[63] ? -{in_item.b_high, in_item.b_low}
                                    : {in_item.b_high, in_item.b_low};
        end
        x_op <= in_item.a_high[63] ? -{in_item.a_high, in_item.a_low}
                                   : {in_item.a_high, in_item.a_low};
        y_op <= (in_item.cmd == q64_pkg::CMD_MUL)
                ? (in_item.b_high[63] ? -{in_item.b_high, in_item.b_low}
                                      : {in_item.b_high, in_item.b_low})
                : {in_item.b_high, in_item.b_low};
      end
      q64_pkg::OP_MAC: acc <= acc + prod_sh;
      q64_pkg::OP_DSTEP: begin
        dvd <= {dvd[126+FRAC:0], 1'b0};
        if (!rem_sub[128] || rem_sh[128]) begin
          rem <= rem_sub[127:0];
          quo <= {quo[126:0], 1'b1};
        end else begin
          rem <= rem_sh[127:0];
          quo <= {quo[126:0], 1'b0};
        end
      end
      q64_pkg::OP_CHK: begin
        x_op <= {mb[63:0], 64'd0};
        y_op <= quo;
        acc <= '0;
      end
      q64_pkg::OP_FIN: begin
        res.status <= fin_st;
        res.result_high <= fin[127:64];
        res.result_low <= fin[63:0];
      end
      default: ;
    endcase
  end

endmodule

### src/q64_ctrl.sv
// Controller for the Q64.64 unit: sequences multiply and divide steps.
// Uses q64_pkg; drives q64_datapath through dp_cmd_t.
module q64_ctrl #(
  parameter int FRAC = q64_pkg::FRACTION_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic [1:0] in_cmd,
  input  logic out_stall,
  input  q64_pkg::dp_status_t dstat,
  output logic in_stall,
  output logic out_valid,
  output q64_pkg::dp_cmd_t dcmd
);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_CHK, S_MUL2, S_FIN, S_OUT} state_t;

  localparam int DSTEPS = 128 + FRAC;

  state_t state;
  logic [1:0] cmd;
  logic [7:0] cnt;
  logic [3:0] pp;
  logic pp_ok;
  logic [2:0] wsum;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  // limb indices: x = pp[3:2], y = pp[1:0]; word weight = x + y
  assign wsum = {1'b0, pp[3:2]} + {1'b0, pp[1:0]};
  // inverse multiply: drop the four products that form a_low*b_low
  // (x and y limbs both below 2); all other products are kept
  assign pp_ok = (cmd == q64_pkg::CMD_MUL) ? 1'b1
               : !(pp[3] == 1'b0 && pp[1] == 1'b0);

  always_comb begin
    dcmd.op = q64_pkg::OP_NONE;
    dcmd.idx = {1'b0, pp};
    dcmd.shift = {wsum, 5'd0};
    unique case (state)
      S_IDLE: if (in_valid && !in_stall) dcmd.op = q64_pkg::OP_LOAD;
      S_MUL, S_MUL2: if (pp_ok) dcmd.op = q64_pkg::OP_MAC;
      S_DIV: dcmd.op = q64_pkg::OP_DSTEP;
      S_CHK: dcmd.op = q64_pkg::OP_CHK;
      S_FIN: dcmd.op = q64_pkg::OP_FIN;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      cnt <= '0;
      pp <= '0;
      cmd <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && !in_stall) begin
          cmd <= in_cmd;
          pp <= '0;
          cnt <= '0;
          if (in_cmd == q64_pkg::CMD_MUL || in_cmd == q64_pkg::CMD_MINV) state <= S_MUL;
          else state <= S_DIV;
        end
        S_MUL, S_MUL2: begin
          pp <= pp + 4'd1;
          if (pp == 4'hf) state <= S_FIN;
        end
        S_DIV: begin
          cnt <= cnt + 8'd1;
          if ((cmd == q64_pkg::CMD_DIV && dstat.b_zero) ||
              (cmd == q64_pkg::CMD_INV && dstat.v_small)) state <= S_FIN;
          else if (cnt == 8'(DSTEPS - 1))
            state <= (cmd == q64_pkg::CMD_INV) ? S_CHK : S_FIN;
        end
        S_CHK: begin
          cmd <= q64_pkg::CMD_INV;
          pp <= '0;
          state <= S_MUL2;
        end
        S_FIN: begin
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        default: if (!out_valid || !out_stall) state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> in_stall) else $error("input taken while dividing");
  a_fin_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |=> out_valid) else $error("result not presented");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("stalled result dropped");
`endif

endmodule

### src/q64_64_fixed_point_alu.sv
// Top level of the Q64.64 arithmetic unit.
// Uses q64_pkg, q64_ctrl and q64_datapath.
//
// Takes one item at a time. Multiply and multiply-by-inverse run 16 passes
// through one 32x32 multiplier, of which multiply-by-inverse accumulates 12.
// Divide and invert run 192 restoring steps, one quotient bit per cycle, with
// invert adding a check multiply. Zero or small divisors finish early.
module q64_64_fixed_point_alu #(
  parameter int FRACTION_BITS = q64_pkg::FRACTION_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  q64_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output q64_pkg::out_item_t out_data
);

  q64_pkg::dp_cmd_t dcmd;
  q64_pkg::dp_status_t dstat;

  q64_ctrl #(.FRAC(FRACTION_BITS)) u_ctrl (
    .clk, .rst, .in_valid, .in_cmd(in_data.cmd), .out_stall, .dstat,
    .in_stall, .out_valid, .dcmd
  );

  q64_datapath #(.FRAC(FRACTION_BITS)) u_dp (
    .clk, .in_item(in_data), .dcmd, .dstat, .res(out_data)
  );

endmodule

### tb/sv/testbench.sv
// Testbench for the Q64.64 arithmetic unit: random and directed transfers,
// checked against an in-bench arithmetic predictor. Depends on q64_pkg and the RTL top.
module testbench;
  import q64_pkg::*;

  class q64_scoreboard;
    out_item_t pending[$];
    int mismatches;
    int checked;

    function logic [127:0] mag(logic [127:0] v);
      return v[127] ? (~v + 128'd1) : v;
    endfunction

    // floor((n << 64) / d), 128-bit wrap
    function logic [127:0] qdiv(logic [127:0] n, logic [127:0] d);
      logic [255:0] num;
      logic [255:0] q;
      num = {128'd0, n} << 64;
      q = num / {128'd0, d};
      return q[127:0];
    endfunction

    // inverse-multiply sum, low x low term left out
    function logic [127:0] inv_mul(logic [127:0] a, logic [127:0] b);
      logic [255:0] s;
      s = ({192'd0, a[127:64]} * {192'd0, b[127:64]}) << 64;
      s = s + {192'd0, a[127:64]} * {192'd0, b[63:0]};
      s = s + {192'd0, a[63:0]} * {192'd0, b[127:64]};
      return s[191:64];
    endfunction

    function out_item_t predict(in_item_t it);
      out_item_t r;
      logic [127:0] a, b, ma, mb, res, chk;
      logic [255:0] p;
      logic neg;
      a = {it.a_high, it.a_low};
      b = {it.b_high, it.b_low};
      ma = mag(a);
      mb = mag(b);
      neg = a[127] ^ b[127];
      res = '0;
      r.status = ST_OK;
      case (cmd_t'(it.cmd))
        CMD_MUL: begin
          p = {128'd0, ma} * {128'd0, mb};
          res = p[191:64];
          if (p[255:192] != 0) r.status = ST_MUL_OVF;
          if (neg) res = ~res + 128'd1;
        end
        CMD_DIV: begin
          if (mb == 0) r.status = ST_DIV_ZERO;
          else begin
            res = qdiv(ma, mb);
            if (neg) res = ~res + 128'd1;
          end
        end
        CMD_MINV: begin
          res = inv_mul(ma, b);
          if (a[127]) res = ~res + 128'd1;
        end
        default: begin
          if (it.b_low <= 64'd1) r.status = ST_INV_SMALL;
          else begin
            res = qdiv(128'd1 << 64, {64'd0, it.b_low});
            chk = inv_mul({it.b_low, 64'd0}, res);
            if (chk[127:64] != 64'd1) res = res + 128'd1;
          end
        end
      endcase
      r.result_high = res[127:64];
      r.result_low = res[63:0];
      return r;
    endfunction

    function void note_input(in_item_t it);
      pending.push_back(predict(it));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.result_high !== want.result_high || got.result_low !== want.result_low ||
          got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %h_%h st %0d, got %h_%h st %0d",
                   want.result_high, want.result_low, want.status,
                   got.result_high, got.result_low, got.status);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  out_item_t out_data;
  q64_scoreboard board = new();
  longint cycles = 0;
  int sent = 0;
  bit calm = 0;
  int op_count[4];

  q64_64_fixed_point_alu DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial forever #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (out_valid && !out_stall) board.check_result(out_data);
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 36);
    end
    if (cycles > 400000) begin
      $display("timeout");
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [63:0] rnd64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(5))
      0: v = v >> $urandom_range(63);
      1: v = 64'(signed'(v[7:0]));
      default: ;
    endcase
    return v;
  endfunction

  // valid stays up after a transfer until the next item or an idle cycle
  task automatic send(logic [1:0] c, logic [63:0] ah, logic [63:0] al, logic [63:0] bh,
                      logic [63:0] bl);
    in_item_t it;
    it.cmd = c; it.a_high = ah; it.a_low = al; it.b_high = bh; it.b_low = bl;
    while (!calm && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(it);
    op_count[c]++;
    sent++;
  endtask

  localparam logic [63:0] MAXP = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] MINN = 64'h8000_0000_0000_0000;

  initial begin
    int wait_cnt;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed corners
    send(CMD_MUL, 64'd1, 64'd0, 64'd1, 64'd0);
    send(CMD_MUL, MAXP, '1, MAXP, '1);
    send(CMD_MUL, MINN, 64'd0, MINN, 64'd0);
    send(CMD_MUL, MINN, 64'd0, '1, '1);
    send(CMD_MUL, '1, '1, 64'd3, 64'h8000_0000_0000_0000);
    send(CMD_DIV, 64'd1, 64'd0, 64'd0, 64'd0);
    send(CMD_DIV, MINN, 64'd0, 64'd0, 64'd1);
    send(CMD_DIV, MAXP, '1, MINN, 64'd0);
    send(CMD_DIV, 64'd7, 64'd0, '1, 64'd0);
    send(CMD_DIV, 64'd0, 64'd0, 64'd3, 64'd0);
    send(CMD_MINV, MINN, 64'd0, MAXP, '1);
    send(CMD_MINV, MAXP, '1, '1, '1);
    send(CMD_MINV, 64'd5, 64'd7, 64'd0, 64'd3);
    send(CMD_INV, '1, '1, '1, 64'd0);
    send(CMD_INV, 64'd0, 64'd0, 64'd0, 64'd1);
    send(CMD_INV, 64'd0, 64'd0, 64'd0, 64'd2);
    send(CMD_INV, 64'd0, 64'd0, 64'd0, 64'd3);
    send(CMD_INV, 64'd0, 64'd0, 64'd0, '1);
    send(CMD_INV, 64'd0, 64'd0, 64'd0, MINN);
    for (int i = 0; i < 400; i++) begin
      calm = (i >= 150 && i < 220);  // stretch with no idling on either side
      send(2'($urandom_range(3)), rnd64(), rnd64(), rnd64(),
           ($urandom_range(15) == 0) ? 64'($urandom_range(1)) : rnd64());
    end
    in_valid <= 1'b0;
    wait_cnt = 0;
    while (board.pending.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (300) @(posedge clk);
    $display("sent %0d transfers (mul %0d, div %0d, minv %0d, inv %0d), checked %0d",
             sent, op_count[0], op_count[1], op_count[2], op_count[3], board.checked);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d outstanding", board.mismatches, board.pending.size());
      $display("tb: failure");
    end
    $finish;
  end
endmodule
